FILE: design/pem_pkg.sv
// Shared constants, types and helper functions for the Prewitt edge magnitude block.
package pem_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Field and counter widths
    localparam int SIZE_W = 11;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int PIX_W  = 8;
    localparam int LINE_W = 2 * PIX_W;
    localparam int GRAD_W = 10;
    localparam int MAG_W  = 11;
    localparam int RAD_W  = 2 * GRAD_W + 1;

    // Integer square root: digit-by-digit, a few steps per cycle
    localparam int ROOT_STEPS   = (RAD_W + 3) / 2;
    localparam int ROOT_W       = 2 * ROOT_STEPS - 1;
    localparam int ROOT_PER_CYC = 4;
    localparam int ROOT_CYC     = (ROOT_STEPS + ROOT_PER_CYC - 1) / ROOT_PER_CYC;
    localparam int ITER_W       = (ROOT_CYC > 1) ? $clog2(ROOT_CYC) : 1;

    // Register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = SIZE_W'(480);

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_GRAD,
        S_SQUARE,
        S_ROOT,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic load;
        logic grad;
        logic square;
        logic root;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic skip;
        logic hit;
        logic out_free;
    } t_sts;

    // Square root working state
    typedef struct packed {
        logic [RAD_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] probe;
    } t_root;

    // Size register to working size: below 2 acts as 2, above the limit as the limit
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_W'(2)) begin
            r = SIZE_W'(2);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // One digit of the restoring square root
    function automatic t_root root_step(input t_root s);
        logic [ROOT_W:0] trial;
        t_root           r;
        trial   = {1'b0, s.root} + {1'b0, s.probe};
        r.probe = s.probe >> 2;
        if ({{(ROOT_W + 1 - RAD_W){1'b0}}, s.rem} >= trial) begin
            r.rem  = s.rem - trial[RAD_W-1:0];
            r.root = (s.root >> 1) + s.probe;
        end else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

FILE: design/pem_stream_if.sv
// Valid/ready stream interfaces for the pixel input and the gradient result channels.
interface pem_pix_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [pem_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output kind, output pixel, input ready);
    modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface pem_res_if;
    logic                       valid;
    logic                       ready;
    logic [pem_pkg::GRAD_W-1:0] grad_horizontal;
    logic [pem_pkg::GRAD_W-1:0] grad_vertical;
    logic [pem_pkg::MAG_W-1:0]  magnitude;
    logic                       row_end;
    logic                       frame_end;

    modport source (output valid, output grad_horizontal, output grad_vertical,
                    output magnitude, output row_end, output frame_end, input ready);
    modport sink   (input valid, input grad_horizontal, input grad_vertical,
                    input magnitude, input row_end, input frame_end, output ready);
endinterface

FILE: design/prewitt_edge_magnitude.sv
// Top level: Prewitt 3x3 edge magnitude over a raster pixel stream, with an APB register port.
//
// Usage:
//   i_pix carries one beat per pixel in raster order (kind 0), then flush beats
//   (kind 1) after the last pixel of a frame; frame_width + 1 flush beats drain
//   the remaining results. A flush beat in mid-frame is taken and dropped.
//   o_res carries the absolute horizontal and vertical Prewitt sums, the integer
//   square root of their squared sum, and row_end / frame_end markers. Results
//   trail their pixel by one row plus one pixel; zero padding outside the frame.
//   Registers: frame_width at byte 0, frame_height at byte 4 (11 bits each).
//   A register write restarts the frame; write only while the block is idle.
// Timing:
//   One beat is handled at a time. A dropped flush beat ends in the idle state, any
//   other beat without a result after the line buffer load; a beat with a result passes
//   line buffer read, window/gradient, squaring, then the square root unit at
//   four digits per cycle. The output register lets the next beat be taken
//   while a result waits; if o_res is still stalled when the next result is
//   ready, the sequencer holds and i_pix.ready stays low.
// Reset: synchronous, active low; position counters and handshakes clear,
//   sizes return to 640 x 480. Line buffer contents are never seen before
//   written, padding masks them, so no clearing pass is needed.
module prewitt_edge_magnitude (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pem_pix_if.sink                      i_pix,
    pem_res_if.source                    o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pem_pkg::APB_AW-1:0]   paddr,
    input  logic [pem_pkg::APB_DW-1:0]   pwdata,
    output logic [pem_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    logic [pem_pkg::SIZE_W-1:0] r_frame_width, r_frame_height;
    logic [pem_pkg::SIZE_W-1:0] width_eff, height_eff;
    logic                       cfg_we;
    pem_pkg::t_reg_idx          reg_idx;
    pem_pkg::t_cmd              cmd;
    pem_pkg::t_sts              sts;
    logic                       in_ready;
    logic                       out_valid;

    // Register file
    assign cfg_we  = psel && penable && pwrite;
    assign reg_idx = pem_pkg::t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= pem_pkg::FRAME_WIDTH_RESET;
            r_frame_height <= pem_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (reg_idx)
                pem_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[pem_pkg::SIZE_W-1:0];
                pem_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[pem_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pem_pkg::REG_FRAME_WIDTH:  prdata = pem_pkg::APB_DW'(r_frame_width);
            pem_pkg::REG_FRAME_HEIGHT: prdata = pem_pkg::APB_DW'(r_frame_height);
            default:                   prdata = '0;
        endcase
    end

    // Working frame size
    assign width_eff  = pem_pkg::clamp_size(r_frame_width,
                                            pem_pkg::SIZE_W'(pem_pkg::MAX_WIDTH));
    assign height_eff = pem_pkg::clamp_size(r_frame_height,
                                            pem_pkg::SIZE_W'(pem_pkg::MAX_HEIGHT));

    pem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pem_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_restart   (cfg_we),
        .i_width     (width_eff),
        .i_height    (height_eff),
        .i_kind      (i_pix.kind),
        .i_pixel     (i_pix.pixel),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .o_grad_h    (o_res.grad_horizontal),
        .o_grad_v    (o_res.grad_vertical),
        .o_mag       (o_res.magnitude),
        .o_row_end   (o_res.row_end),
        .o_frame_end (o_res.frame_end)
    );

    assign i_pix.ready = in_ready;
    assign o_res.valid = out_valid;

endmodule

FILE: design/pem_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pem_ctrl.sv
// Sequencer: steps one pixel beat through line buffer, gradient, square root and output.
module pem_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pem_pkg::t_sts   i_sts,
    output pem_pkg::t_cmd   o_cmd
);

    localparam logic [pem_pkg::ITER_W-1:0] ITER_LAST = pem_pkg::ITER_W'(pem_pkg::ROOT_CYC - 1);

    pem_pkg::t_state                 r_state, n_state;
    logic [pem_pkg::ITER_W-1:0]      r_iter, n_iter;

    // State and iteration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pem_pkg::S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_iter     = r_iter;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            pem_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                // a flush beat in mid-frame is taken and dropped
                if (i_in_valid && !i_sts.skip) begin
                    o_cmd.take = 1'b1;
                    n_state    = pem_pkg::S_LOAD;
                end
            end
            pem_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = i_sts.hit ? pem_pkg::S_GRAD : pem_pkg::S_IDLE;
            end
            pem_pkg::S_GRAD: begin
                o_cmd.grad = 1'b1;
                n_state    = pem_pkg::S_SQUARE;
            end
            pem_pkg::S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_iter       = '0;
                n_state      = pem_pkg::S_ROOT;
            end
            pem_pkg::S_ROOT: begin
                o_cmd.root = 1'b1;
                if (r_iter == ITER_LAST) begin
                    n_state = pem_pkg::S_EMIT;
                end else begin
                    n_iter = r_iter + pem_pkg::ITER_W'(1);
                end
            end
            pem_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = pem_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pem_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/pem_dp.sv
// Datapath: position counters, line buffer, 3x3 window, Prewitt sums, square root, output register.
module pem_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pem_pkg::t_cmd                i_cmd,
    output pem_pkg::t_sts                o_sts,
    input  logic                         i_restart,
    input  logic [pem_pkg::SIZE_W-1:0]   i_width,
    input  logic [pem_pkg::SIZE_W-1:0]   i_height,
    input  logic                         i_kind,
    input  logic [pem_pkg::PIX_W-1:0]    i_pixel,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pem_pkg::GRAD_W-1:0]   o_grad_h,
    output logic [pem_pkg::GRAD_W-1:0]   o_grad_v,
    output logic [pem_pkg::MAG_W-1:0]    o_mag,
    output logic                         o_row_end,
    output logic                         o_frame_end
);

    localparam int PW = pem_pkg::PIX_W;
    localparam int GW = pem_pkg::GRAD_W;

    logic [pem_pkg::COL_W-1:0]  r_col;
    logic [pem_pkg::ROW_W-1:0]  r_row;
    logic [PW-1:0]              r_pix;
    logic [PW-1:0]              r_win [3][3];
    logic                       r_m_left, r_m_right, r_m_top, r_m_bot;
    logic [GW-1:0]              r_ah, r_av;
    logic                       r_row_end, r_frame_end;
    pem_pkg::t_root             r_rs;
    logic                       r_out_valid;
    logic [GW-1:0]              r_out_h, r_out_v;
    logic [pem_pkg::MAG_W-1:0]  r_out_mag;
    logic                       r_out_row_end, r_out_frame_end;

    logic [pem_pkg::COL_W-1:0]  col_eff;
    logic [pem_pkg::SIZE_W-1:0] col_inc;
    logic [pem_pkg::ROW_W-1:0]  row_h;
    logic                       col_nz, draining, hit;
    logic                       m_left, m_right, m_top, m_bot;
    logic [pem_pkg::LINE_W-1:0] line_rd, line_wr;
    logic [PW-1:0]              line_upper, line_middle;
    logic [PW-1:0]              p [3][3];
    logic [GW-1:0]              sum_r, sum_l, sum_b, sum_t;
    logic [GW-1:0]              abs_h, abs_v;
    logic [2*GW-1:0]            sq_h, sq_v;
    pem_pkg::t_root             rs_chain [pem_pkg::ROOT_PER_CYC+1];

    // Current column, wrapped if the width shrank under it
    assign col_eff = (pem_pkg::SIZE_W'(r_col) >= i_width) ? '0 : r_col;
    assign col_inc = pem_pkg::SIZE_W'(col_eff) + pem_pkg::SIZE_W'(1);
    assign row_h   = pem_pkg::ROW_W'(i_height);
    assign col_nz  = (col_eff != '0);

    // Past the last frame row every beat is a flush tick
    assign draining = (r_row >= row_h);

    // Result position relative to this beat, and its zero padding
    assign hit     = col_nz ? (r_row >= pem_pkg::ROW_W'(1)) : (r_row >= pem_pkg::ROW_W'(2));
    assign m_left  = (col_eff == pem_pkg::COL_W'(1));
    assign m_right = !col_nz;
    assign m_top   = col_nz ? (r_row == pem_pkg::ROW_W'(1)) : (r_row == pem_pkg::ROW_W'(2));
    assign m_bot   = col_nz ? (r_row == row_h) : (r_row == row_h + pem_pkg::ROW_W'(1));

    assign o_sts.skip     = !draining && i_kind;
    assign o_sts.hit      = hit;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.load) begin
            if (hit && m_right && m_bot) begin
                r_col <= '0;
                r_row <= '0;
            end else if (col_inc >= i_width) begin
                r_col <= '0;
                r_row <= r_row + pem_pkg::ROW_W'(1);
            end else begin
                r_col <= col_inc[pem_pkg::COL_W-1:0];
            end
        end
    end

    // Line buffer: upper row in the high byte, middle row in the low byte
    assign line_upper  = line_rd[pem_pkg::LINE_W-1:PW];
    assign line_middle = line_rd[PW-1:0];
    assign line_wr     = {line_middle, r_pix};

    pem_ram #(
        .WIDTH (pem_pkg::LINE_W),
        .DEPTH (pem_pkg::MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (col_eff),
        .i_wdata (line_wr),
        .i_raddr (col_eff),
        .o_rdata (line_rd)
    );

    // Input sample and window shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pix <= draining ? '0 : i_pixel;
        end
        if (i_cmd.load) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= line_upper;
            r_win[1][2] <= line_middle;
            r_win[2][2] <= r_pix;
            r_m_left    <= m_left;
            r_m_right   <= m_right;
            r_m_top     <= m_top;
            r_m_bot     <= m_bot;
        end
    end

    // Masked window and Prewitt sums
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                if ((k == 0 && r_m_left) || (k == 2 && r_m_right) ||
                    (r == 0 && r_m_top) || (r == 2 && r_m_bot)) begin
                    p[r][k] = '0;
                end else begin
                    p[r][k] = r_win[r][k];
                end
            end
        end
        sum_r = GW'(p[0][2]) + GW'(p[1][2]) + GW'(p[2][2]);
        sum_l = GW'(p[0][0]) + GW'(p[1][0]) + GW'(p[2][0]);
        sum_b = GW'(p[2][0]) + GW'(p[2][1]) + GW'(p[2][2]);
        sum_t = GW'(p[0][0]) + GW'(p[0][1]) + GW'(p[0][2]);
        abs_h = (sum_r >= sum_l) ? (sum_r - sum_l) : (sum_l - sum_r);
        abs_v = (sum_b >= sum_t) ? (sum_b - sum_t) : (sum_t - sum_b);
    end

    assign sq_h = (2*GW)'(r_ah) * (2*GW)'(r_ah);
    assign sq_v = (2*GW)'(r_av) * (2*GW)'(r_av);

    // Square root digits for this cycle
    always_comb begin
        rs_chain[0] = r_rs;
        for (int s = 0; s < pem_pkg::ROOT_PER_CYC; s++) begin
            rs_chain[s+1] = pem_pkg::root_step(rs_chain[s]);
        end
    end

    // Gradient, squared sum and root registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_ah        <= abs_h;
            r_av        <= abs_v;
            r_row_end   <= r_m_right;
            r_frame_end <= r_m_right && r_m_bot;
        end
        if (i_cmd.square) begin
            r_rs.rem   <= pem_pkg::RAD_W'(sq_h) + pem_pkg::RAD_W'(sq_v);
            r_rs.root  <= '0;
            r_rs.probe <= pem_pkg::ROOT_W'(1) << (pem_pkg::ROOT_W - 1);
        end else if (i_cmd.root) begin
            r_rs <= rs_chain[pem_pkg::ROOT_PER_CYC];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_h         <= r_ah;
            r_out_v         <= r_av;
            r_out_mag       <= r_rs.root[pem_pkg::MAG_W-1:0];
            r_out_row_end   <= r_row_end;
            r_out_frame_end <= r_frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_grad_h    = r_out_h;
    assign o_grad_v    = r_out_v;
    assign o_mag       = r_out_mag;
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

endmodule

FILE: design/pem_checker.sv
// Port-level checker for the Prewitt edge magnitude block, bound to the top level.
module pem_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_in_kind,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [pem_pkg::GRAD_W-1:0] i_grad_h,
    input  logic [pem_pkg::GRAD_W-1:0] i_grad_v,
    input  logic [pem_pkg::MAG_W-1:0]  i_mag,
    input  logic                       i_row_end,
    input  logic                       i_frame_end
);

    localparam int CW = 2 * pem_pkg::MAG_W + 1;

    logic [CW-1:0] rad, mag_sq, mag1_sq;

    // Root bracket: mag^2 <= h^2 + v^2 < (mag + 1)^2
    assign rad     = CW'(i_grad_h) * CW'(i_grad_h) + CW'(i_grad_v) * CW'(i_grad_v);
    assign mag_sq  = CW'(i_mag) * CW'(i_mag);
    assign mag1_sq = (CW'(i_mag) + CW'(1)) * (CW'(i_mag) + CW'(1));

    // Result beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // No result right after reset
    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_mag_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (mag_sq <= rad) && (rad < mag1_sq))
        else $error("magnitude is not the integer root of the squared sum");

    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_end |-> i_row_end)
        else $error("frame end without row end");

    // A pixel beat is always worked on, so the next cycle takes no beat
    a_pix_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_kind |=> !i_in_ready)
        else $error("pixel beat followed by ready in the next cycle");

endmodule

bind prewitt_edge_magnitude pem_checker u_pem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_in_kind   (i_pix.kind),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_grad_h    (o_res.grad_horizontal),
    .i_grad_v    (o_res.grad_vertical),
    .i_mag       (o_res.magnitude),
    .i_row_end   (o_res.row_end),
    .i_frame_end (o_res.frame_end)
);
